// File: rtl/lpd_pkg.sv
// shared constants and types for the lidar packet deframer
package lpd_pkg;

	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned PACKET_BYTES   = 22;
	localparam int unsigned DISTANCE_COUNT = 4;
	// highest byte index that the decode reads is 5 + 4 * (DISTANCE_COUNT - 1)
	localparam int unsigned DECODE_BYTES   = 6 + 4 * (DISTANCE_COUNT - 1);

	localparam int unsigned ANGLE_W = 11;
	localparam int unsigned SPEED_W = 16;
	localparam int unsigned DIST_W  = 14;

	localparam logic [BYTE_W-1:0] HEADER_RESET   = 8'd250;
	localparam logic [BYTE_W-1:0] ANGLE_OFFSET   = 8'hA0;
	localparam logic [5:0]        DIST_HIGH_MASK = 6'h3F;

	typedef logic [DECODE_BYTES-1:0][BYTE_W-1:0] pkt_bytes_t;

	typedef struct packed {
		logic                         complete;
		logic [$clog2(PACKET_BYTES)-1:0] count;
	} collect_status_t;

endpackage

// File: rtl/lidar_packet_deframer.sv
// lidar packet deframer: serial bytes in, one decoded measurement per packet out
// throughput: one byte per cycle; input register, collect/decode logic, result register
// the input stalls only when a completing byte meets a result not yet taken
// reset: asynchronous, clears byte count, valid flags and header value (250)
// the packet store has no reset; every byte that is decoded is written first
module lidar_packet_deframer #(
	parameter int unsigned PACKET_BYTES = lpd_pkg::PACKET_BYTES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rx_valid,
	output logic                               rx_ready,
	input  logic [7:0]                         rx_byte,
	input  logic                               header_we,
	input  logic [7:0]                         header_wdata,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [lpd_pkg::ANGLE_W-1:0] start_angle,
	output logic [lpd_pkg::SPEED_W-1:0]        speed_raw,
	output logic [lpd_pkg::DIST_W-1:0]         distance_0,
	output logic [lpd_pkg::DIST_W-1:0]         distance_1,
	output logic [lpd_pkg::DIST_W-1:0]         distance_2,
	output logic [lpd_pkg::DIST_W-1:0]         distance_3
);

	logic [lpd_pkg::BYTE_W-1:0] header_q;
	logic                       valid_s1;
	logic [lpd_pkg::BYTE_W-1:0] byte_s1;
	logic                       advance;
	logic                       fire;
	lpd_pkg::pkt_bytes_t        bytes;
	logic                       collect_done;
	logic [$clog2(PACKET_BYTES)-1:0] collect_count;
	lpd_pkg::collect_status_t   status;

	logic signed [lpd_pkg::ANGLE_W-1:0] angle_c;
	logic [lpd_pkg::SPEED_W-1:0]        speed_c;
	logic [lpd_pkg::DISTANCE_COUNT-1:0][lpd_pkg::DIST_W-1:0] dist_c;

	logic                               res_valid_q;
	logic signed [lpd_pkg::ANGLE_W-1:0] angle_q;
	logic [lpd_pkg::SPEED_W-1:0]        speed_q;
	logic [lpd_pkg::DISTANCE_COUNT-1:0][lpd_pkg::DIST_W-1:0] dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= lpd_pkg::HEADER_RESET;
		end else if (header_we) begin
			header_q <= header_wdata;
		end
	end

	// held byte moves on unless its packet completes into a full result register that is not being taken
	assign advance  = !(status.complete && res_valid_q && !out_ready);
	assign fire     = valid_s1 && advance;
	assign rx_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	lpd_collect #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_collect (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.byte_in  (byte_s1),
		.header   (header_q),
		.bytes    (bytes),
		.complete (collect_done),
		.count    (collect_count)
	);

	assign status = {collect_done, collect_count};

	lpd_decode u_decode (
		.bytes       (bytes),
		.start_angle (angle_c),
		.speed_raw   (speed_c),
		.distance    (dist_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && status.complete) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && status.complete) begin
			angle_q <= angle_c;
			speed_q <= speed_c;
			dist_q  <= dist_c;
		end
	end

	assign out_valid   = res_valid_q;
	assign start_angle = angle_q;
	assign speed_raw   = speed_q;
	assign distance_0  = dist_q[0];
	assign distance_1  = dist_q[1];
	assign distance_2  = dist_q[2];
	assign distance_3  = dist_q[3];

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.count < ($clog2(PACKET_BYTES))'(PACKET_BYTES - 1) ||
		status.count == ($clog2(PACKET_BYTES))'(PACKET_BYTES - 1))
		else $error("byte count beyond packet length");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && status.complete && res_valid_q && !out_ready |-> !rx_ready)
		else $error("completing byte accepted over a pending result");

	a_result_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1 && status.complete))
		else $error("result raised without a completing byte");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !out_ready |=> res_valid_q && $stable(speed_q))
		else $error("pending result lost");
`endif

endmodule

// File: rtl/lpd_collect.sv
// byte counter and packet store with header resync
module lpd_collect #(
	parameter int unsigned PACKET_BYTES = lpd_pkg::PACKET_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [lpd_pkg::BYTE_W-1:0]    byte_in,
	input  logic [lpd_pkg::BYTE_W-1:0]    header,
	output lpd_pkg::pkt_bytes_t           bytes,
	output logic                          complete,
	output logic [$clog2(PACKET_BYTES)-1:0] count
);

	localparam int unsigned CNT_W = $clog2(PACKET_BYTES);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_eff;
	lpd_pkg::pkt_bytes_t store_q;

	// a header byte restarts collection at index zero
	assign count_eff = (byte_in == header) ? '0 : count_q;
	assign complete  = (count_eff == CNT_W'(PACKET_BYTES - 1));
	assign bytes     = store_q;
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			if (complete) begin
				count_q <= '0;
			end else begin
				count_q <= count_eff + CNT_W'(1);
			end
		end
	end

	// only the bytes up to the highest index that the decode reads are kept
	always_ff @(posedge clk) begin
		for (int i = 0; i < lpd_pkg::DECODE_BYTES; i++) begin
			if (fire && count_eff == CNT_W'(i)) begin
				store_q[i] <= byte_in;
			end
		end
	end

endmodule

// File: rtl/lpd_decode.sv
// field extraction from a held packet
module lpd_decode (
	input  lpd_pkg::pkt_bytes_t                      bytes,
	output logic signed [lpd_pkg::ANGLE_W-1:0]       start_angle,
	output logic [lpd_pkg::SPEED_W-1:0]              speed_raw,
	output logic [lpd_pkg::DISTANCE_COUNT-1:0][lpd_pkg::DIST_W-1:0] distance
);

	logic [lpd_pkg::BYTE_W:0] angle_diff;

	// angle wraps to 11 bits, times four is a shift
	assign angle_diff  = {1'b0, bytes[1]} - {1'b0, lpd_pkg::ANGLE_OFFSET};
	assign start_angle = {angle_diff, 2'b00};
	assign speed_raw   = {bytes[3], bytes[2]};

	always_comb begin
		for (int i = 0; i < lpd_pkg::DISTANCE_COUNT; i++) begin
			distance[i] = {bytes[5 + 4 * i][5:0] & lpd_pkg::DIST_HIGH_MASK, bytes[4 + 4 * i]};
		end
	end

endmodule

// File: bench/tb_top.sv
// testbench for the lidar packet deframer: byte stream in, decoded measurements checked
module tb_top;

	localparam int PHASE_ITEMS = 255;
	localparam int PHASES      = 6;
	localparam int SETTLE      = 6;
	localparam int IDLE_LIMIT  = 2000;

	typedef struct packed {
		logic signed [lpd_pkg::ANGLE_W-1:0] start_angle;
		logic [lpd_pkg::SPEED_W-1:0]        speed_raw;
		logic [lpd_pkg::DIST_W-1:0]         distance_0;
		logic [lpd_pkg::DIST_W-1:0]         distance_1;
		logic [lpd_pkg::DIST_W-1:0]         distance_2;
		logic [lpd_pkg::DIST_W-1:0]         distance_3;
	} meas_t;

	// directed rows: a full packet straight out of reset with no header, then a
	// header arriving inside a partial packet
	localparam int DIR_ROWS = 25;
	localparam logic [7:0] DIR_BYTES [DIR_ROWS] = '{
		8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
		8'h00, 8'h13, 8'hFA
	};
	localparam int    MAX_PKT_END = 21;
	localparam meas_t MAX_PKT_RES = meas_t'({11'sd380, 16'hFFFF,
		14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF});

	logic                               clk          = 1'b0;
	logic                               arst_n       = 1'b0;
	logic                               rx_valid     = 1'b0;
	logic                               rx_ready;
	logic [7:0]                         rx_byte      = 8'h00;
	logic                               header_we    = 1'b0;
	logic [7:0]                         header_wdata = 8'h00;
	logic                               out_valid;
	logic                               out_ready    = 1'b0;
	logic signed [lpd_pkg::ANGLE_W-1:0] start_angle;
	logic [lpd_pkg::SPEED_W-1:0]        speed_raw;
	logic [lpd_pkg::DIST_W-1:0]         distance_0;
	logic [lpd_pkg::DIST_W-1:0]         distance_1;
	logic [lpd_pkg::DIST_W-1:0]         distance_2;
	logic [lpd_pkg::DIST_W-1:0]         distance_3;

	lidar_packet_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.header_we    (header_we),
		.header_wdata (header_wdata),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.start_angle  (start_angle),
		.speed_raw    (speed_raw),
		.distance_0   (distance_0),
		.distance_1   (distance_1),
		.distance_2   (distance_2),
		.distance_3   (distance_3)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// own copy of the deframer state
	logic [7:0] pkt_store [lpd_pkg::PACKET_BYTES];
	int         fill_count = 0;
	logic [7:0] header_cfg = lpd_pkg::HEADER_RESET;
	meas_t      pending_meas [$];
	int         err_count = 0;
	int         burst_left = 0;
	int         idle_cycles = 0;
	int         stall_mode = 0;
	int         cycle_no = 0;

	function automatic bit collect_byte(input logic [7:0] b, output meas_t m);
		int angle;
		if (b == header_cfg)
			fill_count = 0;
		pkt_store[fill_count] = b;
		fill_count++;
		m = '0;
		if (fill_count < lpd_pkg::PACKET_BYTES)
			return 1'b0;
		angle = (int'(pkt_store[1]) - int'(lpd_pkg::ANGLE_OFFSET)) * 4;
		m.start_angle = angle[lpd_pkg::ANGLE_W-1:0];
		m.speed_raw   = {pkt_store[3], pkt_store[2]};
		m.distance_0  = {pkt_store[5][5:0] & lpd_pkg::DIST_HIGH_MASK, pkt_store[4]};
		m.distance_1  = {pkt_store[9][5:0] & lpd_pkg::DIST_HIGH_MASK, pkt_store[8]};
		m.distance_2  = {pkt_store[13][5:0] & lpd_pkg::DIST_HIGH_MASK, pkt_store[12]};
		m.distance_3  = {pkt_store[17][5:0] & lpd_pkg::DIST_HIGH_MASK, pkt_store[16]};
		fill_count = 0;
		return 1'b1;
	endfunction

	// content byte that never restarts the packet, biased towards edge values
	function automatic logic [7:0] pick_content();
		logic [7:0] v;
		case ($urandom_range(0, 7))
			0: v = 8'h00;
			1: v = 8'hFF;
			2: v = lpd_pkg::ANGLE_OFFSET;
			default: v = 8'($urandom);
		endcase
		if (v == header_cfg)
			v = v ^ 8'h01;
		return v;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				rx_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		rx_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!rx_ready) @(posedge clk);
		burst_left--;
	endtask

	task automatic send_predicted(input logic [7:0] b);
		meas_t m;
		send_byte(b);
		if (collect_byte(b, m))
			pending_meas.push_back(m);
	endtask

	task automatic write_header(input logic [7:0] v);
		while (pending_meas.size() != 0) @(posedge clk);
		// a partial packet may still sit in the pipeline
		repeat (SETTLE) @(posedge clk);
		header_we    <= 1'b1;
		header_wdata <= v;
		@(posedge clk);
		header_we  <= 1'b0;
		header_cfg = v;
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		meas_t m;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_meas.size() == 0) begin
				$error("measurement with none expected");
				err_count++;
			end else begin
				m = pending_meas.pop_front();
				check_field("start_angle", int'(m.start_angle), int'(start_angle));
				check_field("speed_raw", int'(m.speed_raw), int'(speed_raw));
				check_field("distance_0", int'(m.distance_0), int'(distance_0));
				check_field("distance_1", int'(m.distance_1), int'(distance_1));
				check_field("distance_2", int'(m.distance_2), int'(distance_2));
				check_field("distance_3", int'(m.distance_3), int'(distance_3));
			end
		end
	end

	// receiver stalls, in a randomly chosen pattern that changes over the run
	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (cycle_no % 5 != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((rx_valid && rx_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		int         sent;
		int         kind;
		int         len;
		logic [7:0] fill;
		meas_t      m;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == MAX_PKT_END) begin
				send_byte(DIR_BYTES[i]);
				void'(collect_byte(DIR_BYTES[i], m));
				pending_meas.push_back(MAX_PKT_RES);
			end else begin
				send_predicted(DIR_BYTES[i]);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: ;
				1: write_header(8'h00);
				2: write_header(8'hFF);
				3: write_header(8'($urandom));
				4: write_header(lpd_pkg::ANGLE_OFFSET);
				default: write_header(lpd_pkg::HEADER_RESET);
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				kind = $urandom_range(0, 99);
				if (kind < 60) begin
					send_predicted(header_cfg);
					for (int k = 1; k < lpd_pkg::PACKET_BYTES; k++)
						send_predicted(pick_content());
					sent += lpd_pkg::PACKET_BYTES;
				end else if (kind < 70) begin
					// all-zero or all-ones content hits the field extremes
					fill = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					if (fill == header_cfg)
						fill = fill ^ 8'h01;
					send_predicted(header_cfg);
					for (int k = 1; k < lpd_pkg::PACKET_BYTES; k++)
						send_predicted(fill);
					sent += lpd_pkg::PACKET_BYTES;
				end else if (kind < 85) begin
					// truncated packet, the next header drops it
					len = $urandom_range(0, lpd_pkg::PACKET_BYTES - 2);
					send_predicted(header_cfg);
					for (int k = 0; k < len; k++)
						send_predicted(pick_content());
					sent += len + 1;
				end else begin
					len = $urandom_range(1, 30);
					for (int k = 0; k < len; k++)
						send_predicted(8'($urandom));
					sent += len;
				end
			end
			rx_valid <= 1'b0;
		end

		while (pending_meas.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// File: filelist.f
rtl/lpd_pkg.sv
rtl/lpd_collect.sv
rtl/lpd_decode.sv
rtl/lidar_packet_deframer.sv
bench/tb_top.sv
